@@ design/fpl_pkg.sv @@
// ----------------------------------------------------------------------------
// fpl_pkg
// Shared types and constants of the frame pacing limiter.
// ----------------------------------------------------------------------------
package fpl_pkg;

   localparam int TIME_W     = 32;
   localparam int WAIT_W     = 20;
   localparam int RATE_W     = 28;
   localparam int TR_W       = 10;
   localparam int UI_W       = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TR_W;

   localparam int WINDOW_DEF     = 120;
   localparam int MS_PER_S       = 1000;
   localparam int RATE_SCALE     = 256 * MS_PER_S;
   localparam int WAIT_MAX       = (1 << WAIT_W) - 1;
   localparam int TR_RESET       = 60;
   localparam int UI_RESET       = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_INTERVAL = 1'd1;

   typedef struct packed {
      logic [TIME_W-1:0] time_check;
      logic [TIME_W-1:0] time_mark;
      logic              measure;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_DIV1,
      BK_PUSH,
      BK_OLD2,
      BK_DIV2,
      BK_OUT
   } back_state_type;

endpackage

@@ design/fpl_req_if.sv @@
// ----------------------------------------------------------------------------
// fpl_req_if
// Frame request channel: check and mark time stamps.
// ----------------------------------------------------------------------------
interface fpl_req_if;
   import fpl_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_check;
   logic [TIME_W-1:0] time_mark;

   modport source (output valid, output time_check, output time_mark, input ready);
   modport sink   (input valid, input time_check, input time_mark, output ready);
endinterface

@@ design/fpl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fpl_rsp_if
// Frame response channel: wait time and measured rate.
// ----------------------------------------------------------------------------
interface fpl_rsp_if;
   import fpl_pkg::*;

   logic              valid;
   logic              ready;
   logic [WAIT_W-1:0] wait_ms;
   logic [RATE_W-1:0] rate_q8;
   logic              rate_updated;

   modport source (output valid, output wait_ms, output rate_q8, output rate_updated,
                   input ready);
   modport sink   (input valid, input wait_ms, input rate_q8, input rate_updated,
                   output ready);
endinterface

@@ design/fpl_ram.sv @@
// ----------------------------------------------------------------------------
// fpl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 120
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ design/fpl_queue.sv @@
// ----------------------------------------------------------------------------
// fpl_queue
// Two entry queue of classified frame transactions.
// ----------------------------------------------------------------------------
module fpl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fpl_pkg::item_type push_item,
   output logic              full,
   output logic              head_valid,
   output fpl_pkg::item_type head_item,
   input  logic              pop
);
   import fpl_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push;
   logic       do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = q_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule

@@ design/fpl_front.sv @@
// ----------------------------------------------------------------------------
// fpl_front
// Accepts frame transactions, tags rate measurement frames, queues them.
// ----------------------------------------------------------------------------
module fpl_front (
   input  logic                    clock,
   input  logic                    reset,
   fpl_req_if.sink                 req_ch,
   input  logic [fpl_pkg::UI_W-1:0] update_interval,
   output logic                    item_valid,
   output fpl_pkg::item_type       item,
   input  logic                    pop
);
   import fpl_pkg::*;

   logic [UI_W-1:0] frame_cnt_ff;
   logic [UI_W-1:0] frame_cnt_in;
   logic [UI_W-1:0] cnt_next;
   logic            full;
   logic            accept;
   item_type        new_item;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;
   assign cnt_next     = frame_cnt_ff + UI_W'(1);

   always_comb begin
      new_item.time_check = req_ch.time_check;
      new_item.time_mark  = req_ch.time_mark;
      new_item.measure    = (cnt_next == update_interval);
      frame_cnt_in        = new_item.measure ? '0 : cnt_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cnt_ff <= '0;
      end else if (accept) begin
         frame_cnt_ff <= frame_cnt_in;
      end
   end

   fpl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (new_item),
      .full       (full),
      .head_valid (item_valid),
      .head_item  (item),
      .pop        (pop)
   );
endmodule

@@ design/fpl_div.sv @@
// ----------------------------------------------------------------------------
// fpl_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpl_div #(
   parameter int NUM_W = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NUM_W-1:0]          num,
   input  logic [fpl_pkg::TIME_W-1:0] den,
   output logic                      done,
   output logic [NUM_W-1:0]          quot
);
   import fpl_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [TIME_W-1:0]  rem_ff;
   logic [TIME_W-1:0]  den_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic [TIME_W:0]    shifted;
   logic               ge;
   logic [TIME_W-1:0]  rem_in;
   logic [NUM_W-1:0]   quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      ge      = (shifted >= {1'b0, den_ff});
      rem_in  = ge ? TIME_W'(shifted - {1'b0, den_ff}) : TIME_W'(shifted);
      quo_in  = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

@@ design/fpl_back.sv @@
// ----------------------------------------------------------------------------
// fpl_back
// Executes queued frames: wait calculation, stamp window, rate measurement.
// ----------------------------------------------------------------------------
module fpl_back #(
   parameter int WINDOW = fpl_pkg::WINDOW_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  fpl_pkg::item_type       item,
   output logic                    pop,
   input  logic [fpl_pkg::TR_W-1:0] target_rate,
   fpl_rsp_if.source               rsp_ch
);
   import fpl_pkg::*;

   localparam int AW       = $clog2(WINDOW);
   localparam int CW       = $clog2(WINDOW + 1);
   localparam int RATE_NUM = RATE_SCALE * (WINDOW - 1);
   localparam int NUM_W    = $clog2(RATE_NUM + 1);
   localparam int EXT_W    = TIME_W + 2;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = (CW+1)'(a) + (CW+1)'(b);
      if (s >= (CW+1)'(WINDOW)) begin
         s = s - (CW+1)'(WINDOW);
      end
      return s[AW-1:0];
   endfunction

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [AW-1:0]     head_ff;
   logic [CW-1:0]     count_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [TIME_W-1:0] oldest_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic              upd_ff;
   logic              rsp_valid_ff;
   logic [WAIT_W-1:0] rsp_wait_ff;
   logic [RATE_W-1:0] rsp_rate_ff;
   logic              rsp_upd_ff;

   logic              full;
   logic              out_free;
   logic              meas_go;
   logic [TIME_W-1:0] span;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [TIME_W-1:0] ram_rdata;
   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic [TIME_W-1:0] div_den;
   logic              div_done;
   logic [NUM_W-1:0]  div_quot;
   logic [TIME_W-1:0] diff;
   logic [EXT_W-1:0]  wait_raw;
   logic [WAIT_W-1:0] wait_sat;

   assign full     = (count_ff == CW'(WINDOW));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign span     = item.time_mark - ram_rdata;
   assign meas_go  = item.measure && full && (span != '0);

   always_comb begin
      diff     = item.time_check - oldest_ff;
      wait_raw = EXT_W'(div_quot) - {{2{diff[TIME_W-1]}}, diff};
      if (wait_raw[EXT_W-1]) begin
         wait_sat = '0;
      end else if (wait_raw > EXT_W'(WAIT_MAX)) begin
         wait_sat = WAIT_W'(WAIT_MAX);
      end else begin
         wait_sat = wait_raw[WAIT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (item_valid) state_in = BK_READ;
         BK_READ: state_in = BK_DIV1;
         BK_DIV1: if (div_done) state_in = BK_PUSH;
         BK_PUSH: state_in = BK_OLD2;
         BK_OLD2: state_in = meas_go ? BK_DIV2 : BK_OUT;
         BK_DIV2: if (div_done) state_in = BK_OUT;
         BK_OUT:  if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = head_ff;
      ram_re    = 1'b0;
      ram_raddr = head_ff;
      div_start = 1'b0;
      div_num   = NUM_W'(RATE_NUM);
      div_den   = span;
      pop       = 1'b0;
      unique case (state_ff)
         BK_IDLE: ram_re = item_valid;
         BK_READ: begin
            div_start = 1'b1;
            div_num   = NUM_W'(count_ff) * NUM_W'(MS_PER_S);
            div_den   = (target_rate == '0) ? TIME_W'(1) : TIME_W'(target_rate);
         end
         BK_PUSH: begin
            ram_we    = 1'b1;
            ram_waddr = full ? head_ff : ring_add(head_ff, count_ff);
            ram_re    = 1'b1;
            ram_raddr = full ? ring_add(head_ff, CW'(1)) : head_ff;
         end
         BK_OLD2: div_start = meas_go;
         BK_OUT:  pop = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_READ) begin
         oldest_ff <= ram_rdata;
      end
      if (state_ff == BK_DIV1 && div_done) begin
         wait_ff <= (count_ff == '0) ? '0 : wait_sat;
      end
      if (state_ff == BK_PUSH) begin
         upd_ff <= 1'b0;
      end else if (state_ff == BK_DIV2 && div_done) begin
         upd_ff <= 1'b1;
      end
      if (state_ff == BK_OUT && out_free) begin
         rsp_wait_ff <= wait_ff;
         rsp_rate_ff <= rate_ff;
         rsp_upd_ff  <= upd_ff;
      end
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_PUSH) begin
            if (full) begin
               head_ff <= ring_add(head_ff, CW'(1));
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (state_ff == BK_DIV2 && div_done) begin
            rate_ff <= RATE_W'(div_quot);
         end
         if (state_ff == BK_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.wait_ms      = rsp_wait_ff;
   assign rsp_ch.rate_q8      = rsp_rate_ff;
   assign rsp_ch.rate_updated = rsp_upd_ff;

   fpl_ram #(
      .WIDTH (TIME_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (item.time_mark),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   fpl_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WINDOW))
      else $error("stamp count exceeds window");

   a_head_only_when_full: assert property (@(posedge clock) disable iff (reset)
      head_ff != '0 |-> full)
      else $error("ring head moved before window filled");

   a_push_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_PUSH |=> count_ff == $past(count_ff) + CW'(1) || full)
      else $error("stamp count did not advance on push");

   a_upd_needs_measure: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT && out_free) |=> !rsp_upd_ff || $past(item.measure))
      else $error("rate update on a frame not tagged for measurement");
endmodule

@@ design/frame_pacing_limiter_unit.sv @@
// ----------------------------------------------------------------------------
// frame_pacing_limiter_unit
// Sliding window frame rate limiter: per-frame wait and measured rate.
// ----------------------------------------------------------------------------
// One transaction per frame returns exactly one response. The execution stage
// uses the shared divider, NUM_W = clog2(256000 * (WINDOW-1) + 1) quotient bits
// wide and one quotient bit per cycle, once for the expected time and, when the
// rate is measured, once more for the rate. A response that is not taken holds
// the execution stage in its output step. A two entry queue accepts further
// frames while one executes. Write csr registers only idle.
module frame_pacing_limiter_unit #(
   parameter int WINDOW = fpl_pkg::WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   fpl_req_if.sink                       req_ch,
   fpl_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [fpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpl_pkg::*;

   logic [TR_W-1:0] target_rate_ff;
   logic [UI_W-1:0] update_interval_ff;
   logic            item_valid;
   item_type        item;
   logic            pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_rate_ff     <= TR_W'(TR_RESET);
         update_interval_ff <= UI_W'(UI_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_RATE:     target_rate_ff     <= csr_wdata[TR_W-1:0];
            CSR_UPDATE_INTERVAL: update_interval_ff <= csr_wdata[UI_W-1:0];
            default: ;
         endcase
      end
   end

   fpl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .update_interval (update_interval_ff),
      .item_valid      (item_valid),
      .item            (item),
      .pop             (pop)
   );

   fpl_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .pop         (pop),
      .target_rate (target_rate_ff),
      .rsp_ch      (rsp_ch)
   );
endmodule

@@ bench/frame_pacing_limiter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacing_limiter_unit_tb
// Self-checking bench for the frame pacing limiter. Frames go in over the
// request channel and each one must return one transaction on the response
// channel. A scoreboard keeps its own window of stamps, frame counter and
// measured rate, predicts wait and rate for every accepted frame, and checks
// responses in order. Stimulus is a short directed set followed by phases of
// steady, frozen, noisy and broken clock sequences under several register
// settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module frame_pacing_limiter_unit_tb;
   import fpl_pkg::*;

   typedef struct {
      logic [WAIT_W-1:0] wait_ms;
      logic [RATE_W-1:0] rate_q8;
      logic              rate_updated;
   } pacing_result_type;

   typedef enum {SEG_STEADY, SEG_FROZEN, SEG_NOISE, SEG_BROKEN} segment_kind_type;

   class pacing_tracker_type;
      logic [TIME_W-1:0] stamps [WINDOW_DEF];
      int unsigned       head;
      int unsigned       count;
      logic [7:0]        frame_count;
      logic [RATE_W-1:0] rate;
      logic [TR_W-1:0]   target_rate;
      logic [UI_W-1:0]   interval;
      pacing_result_type expected_q [$];
      int unsigned       mismatches;

      function new();
         head        = 0;
         count       = 0;
         frame_count = '0;
         rate        = '0;
         target_rate = TR_W'(TR_RESET);
         interval    = UI_W'(UI_RESET);
         mismatches  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         unique case (idx)
            CSR_TARGET_RATE: begin
               target_rate = data[TR_W-1:0];
            end
            CSR_UPDATE_INTERVAL: begin
               interval = data[UI_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_frame(logic [TIME_W-1:0] check, logic [TIME_W-1:0] mark);
         pacing_result_type res;
         logic [TIME_W-1:0] diff;
         logic [TIME_W-1:0] span;
         longint            due_ms;
         longint            elapsed;
         longint            slack;
         longint            quot;
         int unsigned       divisor;
         frame_count = frame_count + 8'd1;
         if (count == 0) begin
            res.wait_ms = '0;
         end else begin
            divisor = (target_rate == '0) ? 1 : target_rate;
            due_ms  = (longint'(MS_PER_S) * count) / divisor;
            diff    = check - stamps[head];
            elapsed = longint'($signed(diff));
            slack   = due_ms - elapsed;
            if (slack < 0) begin
               res.wait_ms = '0;
            end else if (slack > WAIT_MAX) begin
               res.wait_ms = WAIT_W'(WAIT_MAX);
            end else begin
               res.wait_ms = slack[WAIT_W-1:0];
            end
         end
         if (count < WINDOW_DEF) begin
            stamps[(head + count) % WINDOW_DEF] = mark;
            count++;
         end else begin
            stamps[head] = mark;
            head = (head + 1) % WINDOW_DEF;
         end
         res.rate_updated = 1'b0;
         if (frame_count == interval) begin
            frame_count = '0;
            if (count == WINDOW_DEF) begin
               span = stamps[(head + count - 1) % WINDOW_DEF] - stamps[head];
               if (span != '0) begin
                  quot = (longint'(RATE_SCALE) * (WINDOW_DEF - 1)) / longint'(span);
                  rate = quot[RATE_W-1:0];
                  res.rate_updated = 1'b1;
               end
            end
         end
         res.rate_q8 = rate;
         expected_q.insert(expected_q.size(), res);
      endfunction

      function void check_result(logic [WAIT_W-1:0] w, logic [RATE_W-1:0] r, logic u);
         pacing_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected transaction wait %0d rate %0d upd %0d",
                        $time, w, r, u);
         end else begin
            want = expected_q[0];
            expected_q.delete(0);
            if (want.wait_ms !== w || want.rate_q8 !== r || want.rate_updated !== u) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch wait %0d/%0d rate %0d/%0d upd %0d/%0d (exp/act)",
                           $time, want.wait_ms, w, want.rate_q8, r, want.rate_updated, u);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fpl_req_if req_bus ();
   fpl_rsp_if rsp_bus ();

   pacing_tracker_type tracker = new();

   logic          req_calm = 1'b0;
   logic          rsp_calm = 1'b0;
   int unsigned   stall_left = 0;

   logic [TIME_W-1:0] now_ms;
   logic [TIME_W-1:0] chk;
   logic [TIME_W-1:0] mrk;
   logic [CSR_DATA_W-1:0] tr_val;
   logic [CSR_DATA_W-1:0] ui_val;
   int unsigned   seg_len;
   int unsigned   sent;
   int unsigned   pick;
   segment_kind_type seg_kind;

   frame_pacing_limiter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned req_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (req_calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   function automatic int unsigned rsp_stall();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (rsp_calm || r < 80) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_result(rsp_bus.wait_ms, rsp_bus.rate_q8, rsp_bus.rate_updated);
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left <= rsp_stall();
         end
      end
   end

   task automatic send_frame(input logic [TIME_W-1:0] check, input logic [TIME_W-1:0] mark,
                             input int unsigned gap);
      req_bus.valid      <= 1'b1;
      req_bus.time_check <= check;
      req_bus.time_mark  <= mark;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_frame(check, mark);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_W-1:0] tr,
                                  input logic [CSR_DATA_W-1:0] ui);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET_RATE;
      csr_wdata <= tr;
      @(posedge clock);
      tracker.write_register(CSR_TARGET_RATE, tr);
      csr_index <= CSR_UPDATE_INTERVAL;
      csr_wdata <= ui;
      @(posedge clock);
      tracker.write_register(CSR_UPDATE_INTERVAL, ui);
      csr_we <= 1'b0;
   endtask

   initial begin
      #15_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.time_check <= '0;
      req_bus.time_mark  <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_TARGET_RATE;
      csr_wdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty window, wrapped and half-range elapsed times
      send_frame(32'd0, 32'd0, req_gap());
      send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, req_gap());
      send_frame(32'd20, 32'd24, req_gap());
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, req_gap());
      send_frame(32'h7FFF_FFFF, 32'd40, req_gap());
      send_frame(32'd50, 32'd60, req_gap());
      drain();

      // zero target rate, measure every frame
      write_registers(10'd0, 10'd1);
      send_frame(32'd30, 32'd61, req_gap());
      send_frame(32'hFFFF_FF00, 32'd70, req_gap());
      send_frame(32'd62, 32'd80, req_gap());
      send_frame(32'd100, 32'd100, req_gap());
      drain();

      // top of the rate field, zero interval
      write_registers(10'd1023, 10'd0);
      send_frame(32'd100, 32'd120, req_gap());
      send_frame(32'hFFFF_FFFF, 32'd0, req_gap());
      send_frame(32'd150, 32'd160, req_gap());
      drain();

      // interval write with upper bits set
      write_registers(10'd1000, 10'h3FF);
      send_frame(32'd200, 32'd201, req_gap());
      send_frame(32'd202, 32'd203, req_gap());
      send_frame(32'h5555_5555, 32'hAAAA_AAAA, req_gap());

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         unique case (phase)
            0: begin tr_val = 10'd1;    ui_val = 10'd1;   end
            1: begin tr_val = 10'd1000; ui_val = 10'd255; end
            2: begin tr_val = 10'd0;    ui_val = 10'd0;   end
            3: begin tr_val = 10'd1023; ui_val = 10'd3;   end
            4: begin tr_val = 10'd60;   ui_val = 10'd60;  end
            default: begin
               tr_val = CSR_DATA_W'($urandom_range(0, 1023));
               ui_val = CSR_DATA_W'($urandom_range(0, 1023));
            end
         endcase
         write_registers(tr_val, ui_val);
         req_calm = (phase % 3 == 1);
         rsp_calm = (phase % 3 == 2);
         now_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20000);
         sent = 0;
         while (sent < 115) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               seg_kind = SEG_STEADY;
               seg_len  = $urandom_range(5, 60);
            end else if (pick < 75) begin
               seg_kind = SEG_FROZEN;
               seg_len  = $urandom_range(125, 135);
            end else if (pick < 87) begin
               seg_kind = SEG_NOISE;
               seg_len  = $urandom_range(1, 8);
            end else begin
               seg_kind = SEG_BROKEN;
               seg_len  = $urandom_range(1, 6);
            end
            repeat (seg_len) begin
               unique case (seg_kind)
                  SEG_STEADY: begin
                     chk = now_ms + $urandom_range(0, 40);
                     mrk = chk + $urandom_range(0, 20);
                  end
                  SEG_FROZEN: begin
                     chk = now_ms + $urandom_range(0, 3);
                     mrk = now_ms;
                  end
                  SEG_NOISE: begin
                     chk = $urandom;
                     mrk = $urandom;
                  end
                  default: begin
                     chk = now_ms - $urandom_range(0, 1000);
                     mrk = $urandom_range(0, 1) ? now_ms - $urandom_range(1, 500)
                                                : now_ms + $urandom_range(1000, 100000);
                  end
               endcase
               now_ms = mrk;
               send_frame(chk, mrk, req_gap());
               sent++;
               if ($urandom_range(0, 199) == 0)
                  drain();
            end
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
